// ===== hdl/sfc_pkg.sv =====
`timescale 1ns / 1ps

package sfc_pkg;

	// Widths fixed by the item and result formats.
	localparam int HASH_W  = 31;
	localparam int VALUE_W = 32;
	localparam int LEN_W   = 6;

	// Signature line geometry.
	localparam int SIG_LEN      = 37;
	localparam int LINE_CAP     = 40;
	localparam int PREFIX_LEN   = 14;
	localparam int HEX_END      = 22;
	localparam int TAG_END      = 34;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Item codes carried by the action field.
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_EOF  = 1'b1;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		logic       is_eof;
		logic       bin_mode;
		logic [7:0] data;
		logic       is_binary;
		logic       is_newline;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_space;
		logic       is_blank;
	} sfc_entry_t;

	// Push request from the front into the queue.
	typedef struct packed {
		logic       push;
		sfc_entry_t entry;
	} sfc_push_t;

endpackage

// ===== hdl/sfc_if.sv =====
`timescale 1ns / 1ps

// Input channel: one file byte or an end-of-file mark per transfer.
interface sfc_item_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

// Result channel: one result per end-of-file mark.
interface sfc_result_if;
	logic                       valid;
	logic                       ready;
	logic [sfc_pkg::HASH_W-1:0] checksum;
	logic                       signature_found;
	logic [sfc_pkg::VALUE_W-1:0] signed_value;
	logic                       checksum_mismatch;
	logic                       binary_detected;

	modport source (output valid, output checksum, output signature_found,
		output signed_value, output checksum_mismatch, output binary_detected,
		input ready);
	modport sink (input valid, input checksum, input signature_found,
		input signed_value, input checksum_mismatch, input binary_detected,
		output ready);
endinterface

// Configuration write channel for the binary_mode register.
interface sfc_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/sfc_front.sv =====
`timescale 1ns / 1ps

module sfc_front (
	input  logic              clk,
	input  logic              arst_n,
	sfc_item_if.sink          item,
	sfc_cfg_if.sink           cfg,
	input  logic              queue_full,
	output sfc_pkg::sfc_push_t push_o
);
	import sfc_pkg::*;

	logic       binary_mode_q;
	logic [7:0] c;

	// The mode register takes every configuration transfer.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			binary_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			binary_mode_q <= cfg.data;
		end
	end

	// An item is taken whenever the queue has room.
	assign item.ready = !queue_full;
	assign c = item.data_byte;

	// Classify the byte independently of any line state.
	always_comb begin
		push_o.push             = item.valid && !queue_full;
		push_o.entry.is_eof     = (item.action == ACT_EOF);
		push_o.entry.bin_mode   = binary_mode_q;
		push_o.entry.data       = c;
		push_o.entry.is_binary  = (c < 8'd7) || (c[7] && c != 8'ha9 && c != 8'hb8);
		push_o.entry.is_newline = (c == 8'h0a);
		push_o.entry.is_space   = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
		push_o.entry.is_blank   = (c == 8'h20);
		push_o.entry.is_hex     = 1'b1;
		push_o.entry.hex_val    = 4'd0;
		priority if (c >= "0" && c <= "9") begin
			push_o.entry.hex_val = c[3:0];
		end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
			push_o.entry.hex_val = c[3:0] + 4'd9;
		end else begin
			push_o.entry.is_hex = 1'b0;
		end
	end
endmodule

// ===== hdl/sfc_queue.sv =====
`timescale 1ns / 1ps

module sfc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  sfc_pkg::sfc_push_t push_i,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output sfc_pkg::sfc_entry_t head
);
	import sfc_pkg::*;

	sfc_entry_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]     wr_ptr_q;
	logic [QUEUE_AW-1:0]     rd_ptr_q;
	logic [QUEUE_AW:0]       count_q;
	logic                    do_push;
	logic                    do_pop;

	assign full    = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push_i.push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_i.entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== hdl/sfc_back.sv =====
`timescale 1ns / 1ps

module sfc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  sfc_pkg::sfc_entry_t head,
	output logic                pop,
	sfc_result_if.source        result
);
	import sfc_pkg::*;

	localparam logic [7:0] PREFIX [PREFIX_LEN] = '{
		"/", "*", " ", "S", "i", "g", "n", "a", "t", "u", "r", "e", ":", " "
	};

	// One step of the shift-register hash.
	function automatic logic [HASH_W-1:0] mix(input logic [HASH_W-1:0] h,
		input logic [7:0] b);
		logic [HASH_W-1:0] r;
		r = {25'd0, h[30:25]}
			^ {h[24:0], 6'd0}
			^ {3'd0, h[24:0], 3'd0}
			^ {23'd0, b};
		return r;
	endfunction

	logic [HASH_W-1:0]  full_q, text_q, start_q;
	logic [LEN_W-1:0]   len_q;
	logic               match_q, seen_q, aborted_q;
	logic [VALUE_W-1:0] value_q;

	logic [HASH_W-1:0]  full_n, text_n, start_n, text_mixed;
	logic [LEN_W-1:0]   len_n;
	logic               match_n, seen_n, aborted_n, ok;
	logic [VALUE_W-1:0] value_n;

	logic                     out_valid_q;
	logic [HASH_W-1:0]        out_sum_q;
	logic                     out_found_q;
	logic [VALUE_W-1:0]       out_value_q;
	logic                     out_mismatch_q;
	logic                     out_binary_q;
	logic                     load_result;

	// End of file waits only while an older result is still untaken.
	assign pop = !empty && (!head.is_eof || !out_valid_q || result.ready);
	assign load_result = pop && head.is_eof;
	assign text_mixed = mix(text_q, head.data);

	// Per-byte state update.
	always_comb begin
		full_n    = mix(full_q, head.data);
		text_n    = text_q;
		start_n   = start_q;
		len_n     = len_q;
		match_n   = match_q;
		seen_n    = seen_q;
		aborted_n = aborted_q;
		value_n   = value_q;
		ok        = 1'b1;
		if (!head.bin_mode && !aborted_q) begin
			if (head.is_binary) begin
				aborted_n = 1'b1;
			end else begin
				text_n = text_mixed;
				if (!seen_q) begin
					if (head.is_newline) begin
						if (len_q == LEN_W'(SIG_LEN) && match_q) begin
							seen_n = 1'b1;
							text_n = start_q;
						end
						start_n = (len_q == LEN_W'(SIG_LEN) && match_q) ? start_q : text_mixed;
						len_n   = '0;
						match_n = 1'b1;
					end else if (len_q < LEN_W'(LINE_CAP)) begin
						priority if (len_q < LEN_W'(PREFIX_LEN)) begin
							ok = (head.data == PREFIX[len_q[3:0]]);
						end else if (len_q < LEN_W'(HEX_END)) begin
							ok = head.is_hex;
							if (head.is_hex) begin
								value_n = {value_q[VALUE_W-5:0], head.hex_val};
							end
						end else if (len_q == LEN_W'(HEX_END)) begin
							ok = head.is_blank;
						end else if (len_q < LEN_W'(TAG_END)) begin
							ok = !head.is_space;
						end else begin
							ok = 1'b1;
						end
						if (!ok) begin
							match_n = 1'b0;
						end
						len_n = len_q + 1'b1;
					end
				end
			end
		end
	end

	// File state; end of file returns it to the start values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q    <= HASH_W'(1);
			text_q    <= HASH_W'(1);
			start_q   <= HASH_W'(1);
			len_q     <= '0;
			match_q   <= 1'b1;
			value_q   <= '0;
			seen_q    <= 1'b0;
			aborted_q <= 1'b0;
		end else if (pop) begin
			if (head.is_eof) begin
				full_q    <= HASH_W'(1);
				text_q    <= HASH_W'(1);
				start_q   <= HASH_W'(1);
				len_q     <= '0;
				match_q   <= 1'b1;
				value_q   <= '0;
				seen_q    <= 1'b0;
				aborted_q <= 1'b0;
			end else begin
				full_q    <= full_n;
				text_q    <= text_n;
				start_q   <= start_n;
				len_q     <= len_n;
				match_q   <= match_n;
				value_q   <= value_n;
				seen_q    <= seen_n;
				aborted_q <= aborted_n;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_result) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, formed from the state before it is cleared.
	always_ff @(posedge clk) begin
		if (load_result) begin
			if (head.bin_mode || aborted_q) begin
				out_sum_q      <= full_q;
				out_found_q    <= 1'b0;
				out_value_q    <= '0;
				out_mismatch_q <= 1'b0;
				out_binary_q   <= !head.bin_mode && aborted_q;
			end else begin
				out_sum_q      <= text_q;
				out_found_q    <= seen_q;
				out_value_q    <= seen_q ? value_q : '0;
				out_mismatch_q <= seen_q && ({1'b0, text_q} != value_q);
				out_binary_q   <= 1'b0;
			end
		end
	end

	assign result.valid             = out_valid_q;
	assign result.checksum          = out_sum_q;
	assign result.signature_found   = out_found_q;
	assign result.signed_value      = out_value_q;
	assign result.checksum_mismatch = out_mismatch_q;
	assign result.binary_detected   = out_binary_q;
endmodule

// ===== hdl/signed_file_checksum_unit.sv =====
`timescale 1ns / 1ps

// Signed file checksum unit. Each item transfer carries one file byte or an
// end-of-file mark; the unit takes one item per clock cycle for as long as the
// result side keeps up. An item is written into the four-entry queue at its
// transfer and is taken from the queue head by the hash engine, which loads
// the checksum result into the result register at an end-of-file mark. The
// only throttle is the result register: an end-of-file mark waits in the queue
// while the previous result is still untaken, and the queue fills behind it.
// binary_mode is sampled with each item and must be written only while the
// unit is idle. Reset clears the control and file state at once, but not the
// queue storage or the result payload; there is no clearing pass.
module signed_file_checksum_unit (
	input  logic       clk,
	input  logic       arst_n,
	sfc_item_if.sink   item,
	sfc_cfg_if.sink    cfg,
	sfc_result_if.source result
);
	import sfc_pkg::*;

	sfc_push_t  push;
	sfc_entry_t head;
	logic       queue_full;
	logic       queue_empty;
	logic       pop;

	// Front: accepts items and classifies bytes.
	sfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg       (cfg),
		.queue_full(queue_full),
		.push_o    (push)
	);

	// Queue between the front and the hash engine.
	sfc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push_i(push),
		.full  (queue_full),
		.empty (queue_empty),
		.pop   (pop),
		.head  (head)
	);

	// Back: hashes, searches for the signature line and reports.
	sfc_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.empty (queue_empty),
		.head  (head),
		.pop   (pop),
		.result(result)
	);
endmodule

// ===== hdl/sfc_checker.sv =====
`timescale 1ns / 1ps

module sfc_assertions (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic                        res_found,
	input logic [sfc_pkg::VALUE_W-1:0] res_value,
	input logic                        res_mismatch,
	input logic                        res_binary
);
	import sfc_pkg::*;

	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// Without a signature there is no value and no mismatch.
	a_no_sig: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_found |-> res_value == '0 && !res_mismatch)
		else $error("value or mismatch reported without a signature");

	// A fallback to the full hash never reports a signature.
	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_binary |-> !res_found)
		else $error("signature reported after binary fallback");

	// A mismatch needs a found signature.
	a_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_mismatch |-> res_found)
		else $error("mismatch without signature");
endmodule

bind signed_file_checksum_unit sfc_assertions u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_found   (result.signature_found),
	.res_value   (result.signed_value),
	.res_mismatch(result.checksum_mismatch),
	.res_binary  (result.binary_detected)
);

// ===== tb/sfc_checker.sv =====
`timescale 1ns / 1ps

// Shared helpers for the checksum testbench: the per-byte hash step, the
// characters of the signature form and the shape of one expected answer.
package sfc_tb_pkg;

	localparam logic [7:0] CH_NL       = 8'h0a;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0d;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_ZERO     = "0";
	localparam logic [7:0] CH_LOWER_A  = "a";
	localparam logic [7:0] CH_UPPER_A  = "A";
	localparam logic [7:0] CH_UPPER_F  = "F";
	localparam logic [7:0] CH_LOWER_F  = "f";
	localparam logic [7:0] CH_NINE     = "9";
	localparam logic [7:0] CH_G        = "g";
	localparam logic [7:0] CH_BELL     = 8'h07;
	localparam logic [7:0] CH_KEEP_A9  = 8'ha9;
	localparam logic [7:0] CH_KEEP_B8  = 8'hb8;

	localparam logic [8*sfc_pkg::PREFIX_LEN-1:0] SIG_PREFIX = "/* Signature: ";
	localparam logic [23:0] SIG_TAIL = " */";

	// One checksum report as it should leave the block.
	typedef struct packed {
		logic [sfc_pkg::HASH_W-1:0]  checksum;
		logic                        found;
		logic [sfc_pkg::VALUE_W-1:0] value;
		logic                        mismatch;
		logic                        bin_det;
	} sfc_answer_t;

	// One step of the 31-bit shift-register hash.
	function automatic logic [30:0] fold_byte(input logic [30:0] h, input logic [7:0] b);
		logic [31:0] t;
		logic [31:0] r;
		t = {7'd0, h[24:0]} << 7;
		r = {26'd0, h[30:25]} ^ (t >> 1) ^ (t >> 4) ^ {24'd0, b};
		return r[30:0];
	endfunction

endpackage

// Watches the item, configuration and result channels, predicts every
// checksum report and compares the reports that come out in order.
module sfc_checker
	import sfc_pkg::*;
	import sfc_tb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_ready,
	input  logic               item_action,
	input  logic [7:0]         item_data,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               res_valid,
	input  logic               res_ready,
	input  logic [HASH_W-1:0]  checksum,
	input  logic               signature_found,
	input  logic [VALUE_W-1:0] signed_value,
	input  logic               checksum_mismatch,
	input  logic               binary_detected,
	output int                 fail_count,
	output int                 pending
);

	// Predicted state of the file being hashed.
	logic               bin_mode;
	logic [HASH_W-1:0]  all_hash;
	logic [HASH_W-1:0]  txt_hash;
	logic [HASH_W-1:0]  line_base_hash;
	int                 line_len;
	logic               line_ok;
	logic [VALUE_W-1:0] sig_value;
	logic               sig_seen;
	logic               txt_aborted;

	sfc_answer_t answers[$];
	int          fails = 0;
	int          answers_left = 0;

	assign fail_count = fails;
	assign pending    = answers_left;

	function automatic void clear_file();
		all_hash       = 1;
		txt_hash       = 1;
		line_base_hash = 1;
		line_len       = 0;
		line_ok        = 1'b1;
		sig_value      = '0;
		sig_seen       = 1'b0;
		txt_aborted    = 1'b0;
	endfunction

	// Text pass for one byte: hash it and track the signature line form.
	function automatic void scan_text_byte(input logic [7:0] c);
		logic ok;
		if (c < CH_BELL || (c[7] && c != CH_KEEP_A9 && c != CH_KEEP_B8)) begin
			txt_aborted = 1'b1;
			return;
		end
		txt_hash = fold_byte(txt_hash, c);
		if (sig_seen)
			return;
		if (c == CH_NL) begin
			// A finished signature line is taken back out of the text hash.
			if (line_len == SIG_LEN && line_ok) begin
				sig_seen = 1'b1;
				txt_hash = line_base_hash;
			end
			line_base_hash = txt_hash;
			line_len       = 0;
			line_ok        = 1'b1;
			return;
		end
		if (line_len >= LINE_CAP)
			return;
		if (line_len < PREFIX_LEN) begin
			ok = (c == SIG_PREFIX[8*(PREFIX_LEN-1-line_len) +: 8]);
		end else if (line_len < HEX_END) begin
			ok = 1'b1;
			if (c >= CH_ZERO && c <= CH_NINE)
				sig_value = {sig_value[VALUE_W-5:0], 4'(c - CH_ZERO)};
			else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
				sig_value = {sig_value[VALUE_W-5:0], 4'(c - CH_LOWER_A + 8'd10)};
			else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
				sig_value = {sig_value[VALUE_W-5:0], 4'(c - CH_UPPER_A + 8'd10)};
			else
				ok = 1'b0;
		end else if (line_len == HEX_END) begin
			ok = (c == CH_SPACE);
		end else if (line_len < TAG_END) begin
			ok = !(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
		end else begin
			ok = 1'b1;
		end
		if (!ok)
			line_ok = 1'b0;
		line_len++;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			fails++;
			$error("%s: expected %0h, actual %0h", name, want, got);
		end
	endfunction

	// Prediction on each item transfer, comparison on each result transfer.
	always @(posedge clk or negedge arst_n) begin
		sfc_answer_t want;
		if (!arst_n) begin
			bin_mode = 1'b0;
			clear_file();
			answers.delete();
			answers_left <= 0;
		end else begin
			if (item_valid && item_ready) begin
				if (item_action == ACT_BYTE) begin
					all_hash = fold_byte(all_hash, item_data);
					if (!bin_mode && !txt_aborted)
						scan_text_byte(item_data);
				end else begin
					if (bin_mode || txt_aborted) begin
						want.checksum = all_hash;
						want.found    = 1'b0;
						want.value    = '0;
						want.mismatch = 1'b0;
						want.bin_det  = !bin_mode && txt_aborted;
					end else begin
						want.checksum = txt_hash;
						want.found    = sig_seen;
						want.value    = sig_seen ? sig_value : '0;
						want.mismatch = sig_seen && ({1'b0, txt_hash} != sig_value);
						want.bin_det  = 1'b0;
					end
					answers.push_back(want);
					clear_file();
				end
			end
			if (cfg_valid && cfg_ready)
				bin_mode = cfg_data;
			if (res_valid && res_ready) begin
				if (answers.size() == 0) begin
					fails++;
					$error("unexpected result transfer, checksum %0h", checksum);
				end else begin
					want = answers.pop_front();
					check_field("checksum", {1'b0, want.checksum}, {1'b0, checksum});
					check_field("signature_found", {31'd0, want.found}, {31'd0, signature_found});
					check_field("signed_value", want.value, signed_value);
					check_field("checksum_mismatch", {31'd0, want.mismatch},
						{31'd0, checksum_mismatch});
					check_field("binary_detected", {31'd0, want.bin_det},
						{31'd0, binary_detected});
				end
			end
			answers_left <= answers.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	import sfc_pkg::*;
	import sfc_tb_pkg::*;

	localparam int RESET_CYCLES   = 11;
	localparam int SETTLE_CYCLES  = 12;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ITEM_TARGET    = 1550;

	typedef enum int {
		FK_SIGNED,
		FK_SIGNED_TWICE,
		FK_BROKEN,
		FK_LONG,
		FK_BINARY,
		FK_NOISE,
		FK_SIG_LAST
	} file_kind_e;

	logic clk = 1'b0;
	logic arst_n;

	sfc_item_if   item_ch ();
	sfc_cfg_if    cfg_ch ();
	sfc_result_if res_ch ();

	int         fail_count;
	int         pending;
	int         sent_items = 0;
	int         phase_no = 0;
	int         stall_cycles = 0;
	logic       steady;
	logic [7:0] file_q[$];

	// Both sides run without gaps for the whole of one phase.
	assign steady = (phase_no == 2);

	// 10 ns clock period.
	always #5 clk = ~clk;

	signed_file_checksum_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.cfg    (cfg_ch),
		.result (res_ch)
	);

	sfc_checker u_chk (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid        (item_ch.valid),
		.item_ready        (item_ch.ready),
		.item_action       (item_ch.action),
		.item_data         (item_ch.data_byte),
		.cfg_valid         (cfg_ch.valid),
		.cfg_ready         (cfg_ch.ready),
		.cfg_data          (cfg_ch.data),
		.res_valid         (res_ch.valid),
		.res_ready         (res_ch.ready),
		.checksum          (res_ch.checksum),
		.signature_found   (res_ch.signature_found),
		.signed_value      (res_ch.signed_value),
		.checksum_mismatch (res_ch.checksum_mismatch),
		.binary_detected   (res_ch.binary_detected),
		.fail_count        (fail_count),
		.pending           (pending)
	);

	// Ends the run when no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Result side: random back-pressure, and one long hold-off in phase 3.
	initial begin
		int   hold;
		logic held;
		hold = 0;
		held = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && phase_no == 3) begin
				held = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= steady || ($urandom_range(99) >= 36);
			end
		end
	end

	// Offers one item, with a random gap first, and waits for its transfer.
	task automatic send_item(input logic act, input logic [7:0] b);
		while (!steady && $urandom_range(99) < 36) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.action    <= act;
		item_ch.data_byte <= b;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		sent_items++;
	endtask

	// Sends the bytes of the file being built, then the end-of-file mark.
	task automatic send_file();
		foreach (file_q[i])
			send_item(ACT_BYTE, file_q[i]);
		send_item(ACT_EOF, 8'($urandom));
		file_q.delete();
	endtask

	// Stops offering items until every report is out and the pipe is empty.
	task automatic settle();
		item_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= mode;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// A character that keeps the text pass alive, whitespace included.
	function automatic logic [7:0] any_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return CH_TAB;
		if (r < 7)
			return 8'($urandom_range(11, 13));
		if (r < 9)
			return CH_KEEP_A9;
		if (r < 11)
			return CH_KEEP_B8;
		return 8'($urandom_range(32, 126));
	endfunction

	function automatic void add_plain_line(input int len, input logic nl);
		repeat (len) file_q.push_back(any_char());
		if (nl)
			file_q.push_back(CH_NL);
	endfunction

	// Inserts a well-formed signature line carrying value v at position at.
	function automatic void add_sig_line(input int at, input logic [31:0] v);
		logic [7:0] sig_bytes[SIG_LEN + 1];
		logic [3:0] nib;
		logic       keep_tail;
		keep_tail = $urandom_range(0, 1);
		for (int i = 0; i < PREFIX_LEN; i++)
			sig_bytes[i] = SIG_PREFIX[8*(PREFIX_LEN-1-i) +: 8];
		for (int i = 0; i < HEX_END - PREFIX_LEN; i++) begin
			nib = v[4*(7-i) +: 4];
			if (nib < 4'd10)
				sig_bytes[PREFIX_LEN + i] = CH_ZERO + 8'(nib);
			else if ($urandom_range(0, 1))
				sig_bytes[PREFIX_LEN + i] = CH_UPPER_A + 8'(nib - 4'd10);
			else
				sig_bytes[PREFIX_LEN + i] = CH_LOWER_A + 8'(nib - 4'd10);
		end
		sig_bytes[HEX_END] = CH_SPACE;
		for (int i = HEX_END + 1; i < TAG_END; i++)
			sig_bytes[i] = 8'($urandom_range(33, 126));
		for (int i = TAG_END; i < SIG_LEN; i++)
			sig_bytes[i] = keep_tail ? SIG_TAIL[8*(SIG_LEN-1-i) +: 8] : any_char();
		sig_bytes[SIG_LEN] = CH_NL;
		for (int i = 0; i <= SIG_LEN; i++)
			file_q.insert(at + i, sig_bytes[i]);
	endfunction

	// Builds one text-mode file, mostly around a signature line.
	task automatic make_text_file();
		int          r, at, n;
		file_kind_e  kind;
		logic [30:0] h;
		logic [7:0]  bad;
		r = $urandom_range(0, 99);
		kind = r < 35 ? FK_SIGNED : r < 45 ? FK_SIGNED_TWICE : r < 65 ? FK_BROKEN :
			r < 75 ? FK_LONG : r < 85 ? FK_BINARY : r < 93 ? FK_NOISE : FK_SIG_LAST;
		repeat ($urandom_range(0, 2)) add_plain_line($urandom_range(0, 14), 1'b1);
		at = file_q.size();
		case (kind)
			FK_SIGNED, FK_SIGNED_TWICE: begin
				// Lines after the signature; the last may lack its newline.
				n = $urandom_range(0, 2);
				for (int i = 0; i < n; i++)
					add_plain_line($urandom_range(0, 14), i < n - 1 || $urandom_range(0, 1));
				if (kind == FK_SIGNED_TWICE)
					add_sig_line(file_q.size(), $urandom);
				// One file in three signs its own text checksum.
				if ($urandom_range(0, 2) == 0) begin
					h = 31'd1;
					foreach (file_q[i])
						h = fold_byte(h, file_q[i]);
					add_sig_line(at, {1'b0, h});
				end else begin
					add_sig_line(at, $urandom);
				end
			end
			FK_BROKEN: begin
				// A signature line with one character or its length off the form.
				add_sig_line(at, $urandom);
				r = $urandom_range(0, 3);
				if (r < 2) begin
					case ($urandom_range(0, 2))
						0: bad = CH_SPACE;
						1: bad = 8'($urandom_range(11, 13));
						default: bad = CH_G;
					endcase
					file_q[at + $urandom_range(0, SIG_LEN - 1)] = bad;
				end else if (r == 2) begin
					file_q.delete(at + TAG_END - 1);
				end else begin
					file_q.insert(at + TAG_END - 1, CH_G);
				end
				add_plain_line($urandom_range(0, 10), $urandom_range(0, 1));
			end
			FK_LONG: begin
				add_plain_line($urandom_range(SIG_LEN, 64), 1'b1);
				add_plain_line(SIG_LEN, $urandom_range(0, 1));
			end
			FK_BINARY: begin
				// A binary byte ahead of an otherwise valid signature line.
				add_plain_line($urandom_range(0, 8), 1'b0);
				if ($urandom_range(0, 1))
					bad = 8'($urandom_range(0, 6));
				else
					bad = {1'b1, 7'($urandom)};
				if (bad == CH_KEEP_A9 || bad == CH_KEEP_B8)
					bad = 8'hff;
				file_q.push_back(bad);
				add_plain_line($urandom_range(0, 8), 1'b1);
				add_sig_line(file_q.size(), $urandom);
				add_plain_line($urandom_range(0, 8), $urandom_range(0, 1));
			end
			FK_NOISE: begin
				repeat ($urandom_range(0, 30)) file_q.push_back(8'($urandom));
			end
			default: begin
				// Signature form on the last line, with no newline after it.
				add_sig_line(file_q.size(), $urandom);
				void'(file_q.pop_back());
			end
		endcase
	endtask

	// Stimulus and verdict.
	initial begin
		logic mode;
		int   n_files;
		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.action    <= ACT_BYTE;
		item_ch.data_byte <= 8'h00;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.data       <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty file in text mode.
		send_file();
		// Edge bytes that keep the text pass alive.
		file_q = '{CH_BELL, CH_KEEP_A9, CH_KEEP_B8, 8'h7f, CH_NL};
		send_file();
		// Bytes that abort the text pass: below bell, high bytes, both extremes.
		file_q = '{CH_LOWER_A, 8'h06, CH_G};
		send_file();
		file_q = '{8'h80};
		send_file();
		file_q = '{8'hff, 8'h00, CH_NL};
		send_file();
		// Bytes taken in binary mode in the middle of a text-mode file.
		send_item(ACT_BYTE, CH_G);
		write_mode(1'b1);
		send_item(ACT_BYTE, 8'h00);
		send_item(ACT_BYTE, 8'hff);
		write_mode(1'b0);
		send_item(ACT_BYTE, CH_NL);
		send_item(ACT_EOF, 8'hff);
		// Binary mode, empty file and a short one.
		write_mode(1'b1);
		send_file();
		file_q = '{8'h55, 8'haa};
		send_file();

		// Random phases; every phase starts from an idle block.
		while (sent_items < ITEM_TARGET) begin
			mode = (phase_no % 3 == 1);
			write_mode(mode);
			phase_no++;
			n_files = $urandom_range(8, 14);
			for (int f = 0; f < n_files && sent_items < ITEM_TARGET; f++) begin
				if (mode)
					repeat ($urandom_range(0, 40)) file_q.push_back(8'($urandom));
				else
					make_text_file();
				send_file();
			end
		end

		settle();
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
